// ===== sv/two_vector_rotation_matrix_macros.svh =====
// Assertion macros shared by the rotation matrix RTL
`ifndef TWO_VECTOR_ROTATION_MATRIX_MACROS_SVH
`define TWO_VECTOR_ROTATION_MATRIX_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define TVRM_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define TVRM_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/tvrm_pkg.sv =====
// Types, widths and arithmetic helpers for the rotation matrix pipeline
`default_nettype none
package tvrm_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int FRAC_BITS   = 14;
    localparam int GUARD_W     = 16;

    localparam int NRM_W  = (SAMPLE_BITS > GUARD_W) ? SAMPLE_BITS : GUARD_W;
    localparam int SUM_W  = 2 * SAMPLE_BITS;
    localparam int NUM_W  = SAMPLE_BITS + FRAC_BITS + 1;
    localparam int QW     = FRAC_BITS + 2;
    localparam int U_W    = FRAC_BITS + 2;
    localparam int MAG_W  = FRAC_BITS + 1;
    localparam int P1_W   = 2 * FRAC_BITS + 1;
    localparam int RP_W   = FRAC_BITS + 2;
    localparam int C_W    = FRAC_BITS + 3;
    localparam int V_W    = FRAC_BITS + 3;
    localparam int VM_W   = FRAC_BITS + 2;
    localparam int PV_W   = 2 * FRAC_BITS + 3;
    localparam int SS_W   = 2 * FRAC_BITS + 4;
    localparam int S_W    = SS_W / 2;
    localparam int OMC_W  = FRAC_BITS + 4;
    localparam int VV_W   = FRAC_BITS + 4;
    localparam int AM_W   = FRAC_BITS + 3;
    localparam int PM_W   = 2 * FRAC_BITS + 5;
    localparam int RQ_W   = FRAC_BITS + 7;
    localparam int E_W    = FRAC_BITS + 9;
    localparam int O_W    = FRAC_BITS + 3;

    localparam int ONE_I     = 2 ** FRAC_BITS;
    localparam int HALF_I    = 2 ** (FRAC_BITS - 1);
    localparam int OUT_MAX_I = (2 ** (FRAC_BITS + 2)) - 1;
    localparam int OUT_MIN_I = -(2 ** (FRAC_BITS + 2));

    typedef logic signed [U_W-1:0]   unit_t;
    typedef logic signed [C_W-1:0]   c_t;
    typedef logic signed [V_W-1:0]   v_t;
    typedef logic signed [OMC_W-1:0] omc_t;
    typedef logic signed [VV_W-1:0]  vv_t;
    typedef logic signed [RQ_W-1:0]  rq_t;
    typedef logic signed [E_W-1:0]   ent_t;
    typedef logic signed [O_W-1:0]   out_t;

    typedef struct packed {
        logic [2:0][SAMPLE_BITS-1:0] mag;
        logic [2:0]                  neg;
    } vec_side_t;

    typedef struct packed {
        c_t        c;
        omc_t      omc;
        v_t  [2:0] v;
        vv_t [5:0] vv;
    } ax_side_t;

    // sign-magnitude product scaled down by 2^F, ties away from zero
    function automatic rq_t rnd_q(input logic [PM_W-1:0] p, input logic neg);
        logic [PM_W:0] t;
        logic [RQ_W-1:0] r;
        t = {1'b0, p} + (PM_W + 1)'(HALF_I);
        r = RQ_W'(t >> FRAC_BITS);
        return neg ? -$signed(r) : $signed(r);
    endfunction

    function automatic logic [MAG_W-1:0] unit_mag(input unit_t u);
        return MAG_W'((u < 0) ? -u : u);
    endfunction

    function automatic out_t sat_out(input ent_t x);
        out_t r;
        if (x > E_W'(OUT_MAX_I))
            r = O_W'(OUT_MAX_I);
        else if (x < E_W'(OUT_MIN_I))
            r = O_W'(OUT_MIN_I);
        else
            r = O_W'(x);
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== sv/tvrm_isqrt.sv =====
// Pipelined integer square root, one result bit per stage, with sideband payload
`default_nettype none
module tvrm_isqrt #(
    parameter int IN_W   = 32,
    parameter int SIDE_W = 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [IN_W-1:0]     radicand,
    input  logic [SIDE_W-1:0]   side_in,
    output logic                out_valid,
    output logic [IN_W/2-1:0]   root,
    output logic [SIDE_W-1:0]   side_out
);
    localparam int N = IN_W / 2;

    // remainder is bounded by twice the partial root, so it needs N+1 bits
    logic [IN_W-1:0]   rad_reg  [N];
    logic [N:0]        rem_reg  [N];
    logic [N-1:0]      root_reg [N];
    logic [SIDE_W-1:0] side_reg [N];
    logic              vld_reg  [N];

    for (genvar g = 0; g < N; g++) begin : g_stage
        logic [IN_W-1:0]   p_rad;
        logic [N:0]        p_rem;
        logic [N-1:0]      p_root;
        logic [SIDE_W-1:0] p_side;
        logic              p_vld;
        logic [N+2:0]      cur;
        logic [N+2:0]      trial;
        logic              take;

        if (g == 0) begin : g_first
            assign p_rad  = radicand;
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_side = side_in;
            assign p_vld  = in_valid;
        end else begin : g_rest
            assign p_rad  = rad_reg[g-1];
            assign p_rem  = rem_reg[g-1];
            assign p_root = root_reg[g-1];
            assign p_side = side_reg[g-1];
            assign p_vld  = vld_reg[g-1];
        end

        assign cur   = {p_rem, p_rad[IN_W-1 -: 2]};
        assign trial = {1'b0, p_root, 2'b01};
        assign take  = (cur >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[g] <= 1'b0;
            else
                vld_reg[g] <= p_vld;
        end

        always_ff @(posedge clk)
        begin
            rad_reg[g]  <= p_rad << 2;
            rem_reg[g]  <= take ? (N + 1)'(cur - trial) : (N + 1)'(cur);
            root_reg[g] <= {p_root[N-2:0], take};
            side_reg[g] <= p_side;
        end
    end

    assign out_valid = vld_reg[N-1];
    assign root      = root_reg[N-1];
    assign side_out  = side_reg[N-1];

endmodule
`default_nettype wire

// ===== sv/tvrm_unit_div.sv =====
// Pipelined restoring divider that scales one 3-vector to Q1.F unit length
`default_nettype none
module tvrm_unit_div (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic [tvrm_pkg::NRM_W-1:0]           norm,
    input  logic [2:0][tvrm_pkg::SAMPLE_BITS-1:0] mag,
    input  logic [2:0]                           neg,
    output logic                                 out_valid,
    output tvrm_pkg::unit_t [2:0]                unit
);
    import tvrm_pkg::*;

    logic [NRM_W-1:0]         d_reg   [QW];
    logic [2:0][NRM_W-1:0]    rem_reg [QW];
    logic [2:0][QW-1:0]       low_reg [QW];
    logic [2:0][QW-1:0]       q_reg   [QW];
    logic [2:0]               neg_reg [QW];
    logic                     vld_reg [QW];

    for (genvar g = 0; g < QW; g++) begin : g_stage
        logic [NRM_W-1:0]      p_d;
        logic [2:0][NRM_W-1:0] p_rem;
        logic [2:0][QW-1:0]    p_low;
        logic [2:0][QW-1:0]    p_q;
        logic [2:0]            p_neg;
        logic                  p_vld;
        logic [2:0][NRM_W:0]   cur;
        logic [2:0]            take;
        logic [2:0][NRM_W-1:0] rem_next;

        if (g == 0) begin : g_first
            logic [2:0][NUM_W-1:0] num;
            always_comb
            begin
                for (int k = 0; k < 3; k++)
                begin
                    num[k]   = NUM_W'(mag[k]) << (FRAC_BITS + 1);
                    p_rem[k] = NRM_W'(num[k] >> QW);
                    p_low[k] = num[k][QW-1:0];
                    p_q[k]   = '0;
                end
            end
            assign p_d   = norm;
            assign p_neg = neg;
            assign p_vld = in_valid;
        end else begin : g_rest
            assign p_d   = d_reg[g-1];
            assign p_rem = rem_reg[g-1];
            assign p_low = low_reg[g-1];
            assign p_q   = q_reg[g-1];
            assign p_neg = neg_reg[g-1];
            assign p_vld = vld_reg[g-1];
        end

        always_comb
        begin
            for (int k = 0; k < 3; k++)
            begin
                cur[k]      = {p_rem[k], p_low[k][QW-1]};
                take[k]     = (cur[k] >= {1'b0, p_d});
                rem_next[k] = take[k] ? NRM_W'(cur[k] - {1'b0, p_d}) : NRM_W'(cur[k]);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[g] <= 1'b0;
            else
                vld_reg[g] <= p_vld;
        end

        always_ff @(posedge clk)
        begin
            d_reg[g]   <= p_d;
            neg_reg[g] <= p_neg;
            for (int k = 0; k < 3; k++)
            begin
                rem_reg[g][k] <= rem_next[k];
                low_reg[g][k] <= p_low[k] << 1;
                q_reg[g][k]   <= {p_q[k][QW-2:0], take[k]};
            end
        end
    end

    // quotient carries one extra bit; halve it with round-half-up
    always_comb
    begin
        logic [QW:0]  qp;
        logic [U_W-1:0] um;
        for (int k = 0; k < 3; k++)
        begin
            qp      = {1'b0, q_reg[QW-1][k]} + (QW + 1)'(1);
            um      = U_W'(qp >> 1);
            unit[k] = neg_reg[QW-1][k] ? -$signed(um) : $signed(um);
        end
    end

    assign out_valid = vld_reg[QW-1];

endmodule
`default_nettype wire

// ===== sv/two_vector_rotation_matrix.sv =====
// Top level: rotation matrix from a measured and a reference field vector
//
//  channel   | handshake              | payload
//  ----------+------------------------+-----------------------------------------
//  input     | start / busy           | meas_x meas_y meas_z ref_x ref_y ref_z
//  config    | cfg_valid / cfg_ready  | cfg_data (norm_guard)
//  result    | done (one-cycle strobe)| m00 .. m22, signed Q3.14
//
// Fully pipelined: one transaction per cycle, busy is never raised.
// The path runs through the 16-step norm square roots, a 16-step divider and a 16-step axis square root.
// Reset clears the valid chain and sets norm_guard to 1; no clearing pass.
// The result side has no backpressure, so nothing in the pipe ever stalls.
`default_nettype none
`include "two_vector_rotation_matrix_macros.svh"
module two_vector_rotation_matrix (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [tvrm_pkg::SAMPLE_BITS-1:0] meas_x,
    input  logic signed [tvrm_pkg::SAMPLE_BITS-1:0] meas_y,
    input  logic signed [tvrm_pkg::SAMPLE_BITS-1:0] meas_z,
    input  logic signed [tvrm_pkg::SAMPLE_BITS-1:0] ref_x,
    input  logic signed [tvrm_pkg::SAMPLE_BITS-1:0] ref_y,
    input  logic signed [tvrm_pkg::SAMPLE_BITS-1:0] ref_z,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [tvrm_pkg::GUARD_W-1:0]         cfg_data,
    output logic                                 done,
    output tvrm_pkg::out_t                       m00,
    output tvrm_pkg::out_t                       m01,
    output tvrm_pkg::out_t                       m02,
    output tvrm_pkg::out_t                       m10,
    output tvrm_pkg::out_t                       m11,
    output tvrm_pkg::out_t                       m12,
    output tvrm_pkg::out_t                       m20,
    output tvrm_pkg::out_t                       m21,
    output tvrm_pkg::out_t                       m22
);
    import tvrm_pkg::*;

    logic                    accept;
    logic [GUARD_W-1:0]      guard_reg;
    logic [GUARD_W-1:0]      guard_eff;
    logic signed [SAMPLE_BITS-1:0] smp [2][3];

    // stage A: magnitudes and squares
    logic                    va_reg;
    logic [SUM_W-1:0]        sq_a_reg   [2][3];
    vec_side_t               side_a_reg [2];

    // norm square roots and dividers
    logic                    vld_n  [2];
    logic [SAMPLE_BITS-1:0]  root_n [2];
    vec_side_t               side_n [2];
    logic [NRM_W-1:0]        nrm    [2];
    logic                    vld_u  [2];
    unit_t [2:0]             unit_u [2];

    // stage D..G
    logic                    vd_reg;
    unit_t [2:0]             u_d_reg [2];
    logic                    ve_reg;
    logic [P1_W-1:0]         pe_reg [3][3];
    logic                    ne_reg [3][3];
    logic                    vf_reg;
    c_t                      c_f_reg;
    v_t                      v_f_reg [3];
    logic                    vg_reg;
    c_t                      c_g_reg;
    v_t                      v_g_reg [3];
    logic [PV_W-1:0]         pv_g_reg [6];
    logic                    nv_g_reg [6];

    // axis length root and final products
    logic [SS_W-1:0]         ss_h;
    ax_side_t                side_h;
    logic                    vld_s;
    logic [S_W-1:0]          s_root;
    logic [$bits(ax_side_t)-1:0] side_s_vec;
    ax_side_t                side_s;
    logic                    vi_reg;
    c_t                      c_i_reg;
    logic [PM_W-1:0]         pa_reg [6];
    logic                    na_reg [6];
    logic [PM_W-1:0]         pw_reg [3];
    logic                    nw_reg [3];

    logic                    done_reg;
    out_t                    m_reg [9];
    logic                    unit_ok;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start & ~busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            guard_reg <= GUARD_W'(1);
        else if (cfg_valid && cfg_ready)
            guard_reg <= cfg_data;
    end

    assign guard_eff = (guard_reg == '0) ? GUARD_W'(1) : guard_reg;

    assign smp[0][0] = meas_x;
    assign smp[0][1] = meas_y;
    assign smp[0][2] = meas_z;
    assign smp[1][0] = ref_x;
    assign smp[1][1] = ref_y;
    assign smp[1][2] = ref_z;

    // ---------------- stage A ----------------
    always_ff @(posedge clk)
    begin
        logic [SAMPLE_BITS-1:0] m;
        for (int v = 0; v < 2; v++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                m = smp[v][k][SAMPLE_BITS-1] ? SAMPLE_BITS'(-smp[v][k])
                                             : SAMPLE_BITS'(smp[v][k]);
                side_a_reg[v].mag[k] <= m;
                side_a_reg[v].neg[k] <= smp[v][k][SAMPLE_BITS-1];
                sq_a_reg[v][k]       <= SUM_W'(m) * SUM_W'(m);
            end
        end
    end

    // ---------------- norms and unit vectors ----------------
    for (genvar v = 0; v < 2; v++) begin : g_vec
        tvrm_isqrt #(
            .IN_W   (SUM_W),
            .SIDE_W ($bits(vec_side_t))
        ) u_nsqrt (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (va_reg),
            .radicand  (sq_a_reg[v][0] + sq_a_reg[v][1] + sq_a_reg[v][2]),
            .side_in   (side_a_reg[v]),
            .out_valid (vld_n[v]),
            .root      (root_n[v]),
            .side_out  (side_n[v])
        );

        assign nrm[v] = (NRM_W'(root_n[v]) < NRM_W'(guard_eff)) ? NRM_W'(guard_eff)
                                                                 : NRM_W'(root_n[v]);

        tvrm_unit_div u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (vld_n[v]),
            .norm      (nrm[v]),
            .mag       (side_n[v].mag),
            .neg       (side_n[v].neg),
            .out_valid (vld_u[v]),
            .unit      (unit_u[v])
        );
    end

    // ---------------- stages D, E, F, G ----------------
    always_ff @(posedge clk)
    begin
        logic [VM_W-1:0] vm [3];
        u_d_reg[0] <= unit_u[0];
        u_d_reg[1] <= unit_u[1];

        // E: b_i * l_j as sign and magnitude
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                pe_reg[i][j] <= P1_W'(unit_mag(u_d_reg[0][i])) *
                                P1_W'(unit_mag(u_d_reg[1][j]));
                ne_reg[i][j] <= u_d_reg[0][i][U_W-1] ^ u_d_reg[1][j][U_W-1];
            end
        end

        // F: cosine and unnormalized axis
        c_f_reg    <= C_W'(RP_W'(rnd_q(PM_W'(pe_reg[0][0]), ne_reg[0][0])))
                    + C_W'(RP_W'(rnd_q(PM_W'(pe_reg[1][1]), ne_reg[1][1])))
                    + C_W'(RP_W'(rnd_q(PM_W'(pe_reg[2][2]), ne_reg[2][2])));
        v_f_reg[0] <= V_W'(RP_W'(rnd_q(PM_W'(pe_reg[2][1]), ne_reg[2][1])))
                    - V_W'(RP_W'(rnd_q(PM_W'(pe_reg[1][2]), ne_reg[1][2])));
        v_f_reg[1] <= V_W'(RP_W'(rnd_q(PM_W'(pe_reg[0][2]), ne_reg[0][2])))
                    - V_W'(RP_W'(rnd_q(PM_W'(pe_reg[2][0]), ne_reg[2][0])));
        v_f_reg[2] <= V_W'(RP_W'(rnd_q(PM_W'(pe_reg[1][0]), ne_reg[1][0])))
                    - V_W'(RP_W'(rnd_q(PM_W'(pe_reg[0][1]), ne_reg[0][1])));

        // G: outer product of the axis; order 00 11 22 01 02 12
        for (int k = 0; k < 3; k++)
            vm[k] = VM_W'((v_f_reg[k] < 0) ? -v_f_reg[k] : v_f_reg[k]);
        c_g_reg     <= c_f_reg;
        v_g_reg     <= v_f_reg;
        pv_g_reg[0] <= PV_W'(PV_W'(vm[0]) * PV_W'(vm[0]));
        pv_g_reg[1] <= PV_W'(PV_W'(vm[1]) * PV_W'(vm[1]));
        pv_g_reg[2] <= PV_W'(PV_W'(vm[2]) * PV_W'(vm[2]));
        pv_g_reg[3] <= PV_W'(PV_W'(vm[0]) * PV_W'(vm[1]));
        pv_g_reg[4] <= PV_W'(PV_W'(vm[0]) * PV_W'(vm[2]));
        pv_g_reg[5] <= PV_W'(PV_W'(vm[1]) * PV_W'(vm[2]));
        nv_g_reg[0] <= 1'b0;
        nv_g_reg[1] <= 1'b0;
        nv_g_reg[2] <= 1'b0;
        nv_g_reg[3] <= v_f_reg[0][V_W-1] ^ v_f_reg[1][V_W-1];
        nv_g_reg[4] <= v_f_reg[0][V_W-1] ^ v_f_reg[2][V_W-1];
        nv_g_reg[5] <= v_f_reg[1][V_W-1] ^ v_f_reg[2][V_W-1];
    end

    // ---------------- axis length ----------------
    always_comb
    begin
        ss_h       = SS_W'(pv_g_reg[0]) + SS_W'(pv_g_reg[1]) + SS_W'(pv_g_reg[2]);
        side_h.c   = c_g_reg;
        side_h.omc = OMC_W'(ONE_I) - OMC_W'(c_g_reg);
        for (int k = 0; k < 3; k++)
            side_h.v[k] = v_g_reg[k];
        for (int k = 0; k < 6; k++)
            side_h.vv[k] = VV_W'(rnd_q(PM_W'(pv_g_reg[k]), nv_g_reg[k]));
    end

    tvrm_isqrt #(
        .IN_W   (SS_W),
        .SIDE_W ($bits(ax_side_t))
    ) u_ssqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vg_reg),
        .radicand  (ss_h),
        .side_in   (side_h),
        .out_valid (vld_s),
        .root      (s_root),
        .side_out  (side_s_vec)
    );

    assign side_s = ax_side_t'(side_s_vec);

    // ---------------- stage I: (1-c)*vv and s*v ----------------
    always_ff @(posedge clk)
    begin
        logic [AM_W-1:0] om;
        logic [AM_W-1:0] vvm;
        logic [VM_W-1:0] vm;
        om = AM_W'((side_s.omc < 0) ? -side_s.omc : side_s.omc);
        c_i_reg <= side_s.c;
        for (int k = 0; k < 6; k++)
        begin
            vvm = AM_W'((side_s.vv[k] < 0) ? -side_s.vv[k] : side_s.vv[k]);
            pa_reg[k] <= PM_W'(PM_W'(om) * PM_W'(vvm));
            na_reg[k] <= side_s.omc[OMC_W-1] ^ side_s.vv[k][VV_W-1];
        end
        for (int k = 0; k < 3; k++)
        begin
            vm = VM_W'((side_s.v[k] < 0) ? -side_s.v[k] : side_s.v[k]);
            pw_reg[k] <= PM_W'(PM_W'(s_root) * PM_W'(vm));
            nw_reg[k] <= side_s.v[k][V_W-1];
        end
    end

    // ---------------- stage J: combine and saturate ----------------
    always_ff @(posedge clk)
    begin
        rq_t a [6];
        rq_t w [3];
        for (int k = 0; k < 6; k++)
            a[k] = rnd_q(pa_reg[k], na_reg[k]);
        for (int k = 0; k < 3; k++)
            w[k] = rnd_q(pw_reg[k], nw_reg[k]);
        m_reg[0] <= sat_out(E_W'(c_i_reg) + E_W'(a[0]));
        m_reg[1] <= sat_out(E_W'(a[3]) + E_W'(w[2]));
        m_reg[2] <= sat_out(E_W'(a[4]) - E_W'(w[1]));
        m_reg[3] <= sat_out(E_W'(a[3]) - E_W'(w[2]));
        m_reg[4] <= sat_out(E_W'(c_i_reg) + E_W'(a[1]));
        m_reg[5] <= sat_out(E_W'(a[5]) + E_W'(w[0]));
        m_reg[6] <= sat_out(E_W'(a[4]) + E_W'(w[1]));
        m_reg[7] <= sat_out(E_W'(a[5]) - E_W'(w[0]));
        m_reg[8] <= sat_out(E_W'(c_i_reg) + E_W'(a[2]));
    end

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg   <= 1'b0;
            vd_reg   <= 1'b0;
            ve_reg   <= 1'b0;
            vf_reg   <= 1'b0;
            vg_reg   <= 1'b0;
            vi_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            va_reg   <= accept;
            vd_reg   <= vld_u[0];
            ve_reg   <= vd_reg;
            vf_reg   <= ve_reg;
            vg_reg   <= vf_reg;
            vi_reg   <= vld_s;
            done_reg <= vi_reg;
        end
    end

    assign done = done_reg;
    assign m00  = m_reg[0];
    assign m01  = m_reg[1];
    assign m02  = m_reg[2];
    assign m10  = m_reg[3];
    assign m11  = m_reg[4];
    assign m12  = m_reg[5];
    assign m20  = m_reg[6];
    assign m21  = m_reg[7];
    assign m22  = m_reg[8];

    always_comb
    begin
        unit_ok = 1'b1;
        for (int v = 0; v < 2; v++)
            for (int k = 0; k < 3; k++)
                if ((u_d_reg[v][k] > U_W'(ONE_I)) || (u_d_reg[v][k] < -U_W'(ONE_I)))
                    unit_ok = 1'b0;
    end

    `TVRM_ASSERT_IMP(a_norm_lanes, 1'b1, vld_n[0] == vld_n[1], "norm lanes out of step")
    `TVRM_ASSERT_IMP(a_div_lanes, 1'b1, vld_u[0] == vld_u[1], "divider lanes out of step")
    `TVRM_ASSERT_IMP(a_norm_nonzero, vld_n[0], (nrm[0] != '0) && (nrm[1] != '0), "zero divisor")
    `TVRM_ASSERT_IMP(a_unit_range, vd_reg, unit_ok, "unit component beyond one")

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the two-vector rotation matrix pipeline
`timescale 1ns / 1ps
`default_nettype none
module testbench;
    import tvrm_pkg::*;

    typedef logic [8:0][O_W-1:0] mat_t;
    typedef struct {
        logic signed [SAMPLE_BITS-1:0] mx, my, mz, rx, ry, rz;
        int gap;
    } pair_t;

    localparam int LATENCY = 54;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [SAMPLE_BITS-1:0] meas_x = '0, meas_y = '0, meas_z = '0;
    logic signed [SAMPLE_BITS-1:0] ref_x = '0, ref_y = '0, ref_z = '0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [GUARD_W-1:0] cfg_data = '0;
    logic done;
    out_t m00, m01, m02, m10, m11, m12, m20, m21, m22;

    pair_t pair_q[$];
    mat_t  matrix_q[$];
    logic [GUARD_W-1:0] guard_copy = GUARD_W'(1);
    int errors = 0;
    int gap_left = 0;
    bit no_idle = 0;
    string entry_name[9] = '{"m00", "m01", "m02", "m10", "m11", "m12", "m20", "m21", "m22"};

    two_vector_rotation_matrix i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .meas_x(meas_x), .meas_y(meas_y), .meas_z(meas_z),
        .ref_x(ref_x), .ref_y(ref_y), .ref_z(ref_z),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .done(done),
        .m00(m00), .m01(m01), .m02(m02), .m10(m10), .m11(m11), .m12(m12),
        .m20(m20), .m21(m21), .m22(m22)
    );

    always #2 clk = ~clk;

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint abs64(input longint a);
        return a < 0 ? -a : a;
    endfunction

    // a*b / 2^F, rounded half away from zero
    function automatic longint qmul(input longint a, input longint b);
        longint r;
        r = (abs64(a) * abs64(b) + HALF_I) >>> FRAC_BITS;
        return ((a < 0) != (b < 0)) ? -r : r;
    endfunction

    function automatic void normalize(input longint x[3], input longint g, output longint u[3]);
        longint unsigned sum, n, q;
        sum = 0;
        for (int k = 0; k < 3; k++)
            sum += abs64(x[k]) * abs64(x[k]);
        n = int_sqrt(sum);
        if (n < g)
            n = g;
        for (int k = 0; k < 3; k++)
        begin
            q = ((abs64(x[k]) << (FRAC_BITS + 1)) / n + 1) >> 1;
            u[k] = x[k] < 0 ? -longint'(q) : longint'(q);
        end
    endfunction

    function automatic mat_t rotation_of(input pair_t p, input logic [GUARD_W-1:0] guard);
        longint ma[3], ra[3], b[3], l[3], v[3], c, omc, s, g, e;
        longint sk[3][3];
        mat_t r;
        g = (guard == 0) ? 1 : guard;
        ma = '{p.mx, p.my, p.mz};
        ra = '{p.rx, p.ry, p.rz};
        normalize(ma, g, b);
        normalize(ra, g, l);
        c = qmul(b[0], l[0]) + qmul(b[1], l[1]) + qmul(b[2], l[2]);
        v[0] = qmul(b[2], l[1]) - qmul(b[1], l[2]);
        v[1] = qmul(b[0], l[2]) - qmul(b[2], l[0]);
        v[2] = qmul(b[1], l[0]) - qmul(b[0], l[1]);
        s = int_sqrt(v[0] * v[0] + v[1] * v[1] + v[2] * v[2]);
        omc = ONE_I - c;
        sk = '{'{0, -v[2], v[1]}, '{v[2], 0, -v[0]}, '{-v[1], v[0], 0}};
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
            begin
                e = qmul(omc, qmul(v[i], v[j])) - qmul(s, sk[i][j]);
                if (i == j)
                    e += c;
                if (e > OUT_MAX_I)
                    e = OUT_MAX_I;
                if (e < OUT_MIN_I)
                    e = OUT_MIN_I;
                r[i * 3 + j] = e[O_W-1:0];
            end
        return r;
    endfunction

    // driver: one item per transaction, random gaps between them
    always @(negedge clk)
    begin
        pair_t p;
        logic next_start;
        if (rst_n)
        begin
            next_start = start && busy;
            if (!next_start)
            begin
                if (gap_left > 0)
                    gap_left <= gap_left - 1;
                else if (pair_q.size() > 0)
                begin
                    p = pair_q.pop_front();
                    meas_x <= p.mx; meas_y <= p.my; meas_z <= p.mz;
                    ref_x <= p.rx; ref_y <= p.ry; ref_z <= p.rz;
                    gap_left <= p.gap;
                    next_start = 1'b1;
                end
            end
            start <= next_start;
        end
    end

    // monitor: check results, predict accepted items, track the guard
    always @(posedge clk)
    begin
        mat_t want, got;
        pair_t p;
        if (rst_n)
        begin
            if (done)
            begin
                got = {m22, m21, m20, m12, m11, m10, m02, m01, m00};
                if (matrix_q.size() == 0)
                begin
                    $error("result with no matrix outstanding");
                    errors++;
                end
                else
                begin
                    want = matrix_q.pop_front();
                    for (int k = 0; k < 9; k++)
                        if (got[k] !== want[k])
                        begin
                            $error("%s expected %0d got %0d", entry_name[k],
                                   $signed(want[k]), $signed(got[k]));
                            errors++;
                        end
                end
            end
            if (start && !busy)
            begin
                p.mx = meas_x; p.my = meas_y; p.mz = meas_z;
                p.rx = ref_x; p.ry = ref_y; p.rz = ref_z;
                matrix_q.push_back(rotation_of(p, guard_copy));
            end
            if (cfg_valid && cfg_ready)
                guard_copy = cfg_data;
        end
    end

    function automatic logic signed [SAMPLE_BITS-1:0] rand_sample(input int scale);
        int m;
        case (scale)
            0: m = $urandom_range(0, 8);
            1: m = $urandom_range(0, 700);
            default: return SAMPLE_BITS'($urandom);
        endcase
        return SAMPLE_BITS'($urandom_range(0, 1) ? -m : m);
    endfunction

    function automatic int rand_gap();
        return no_idle ? 0 : $urandom_range(0, 6);
    endfunction

    task automatic add_pair(input int a, b, cc, d, e, f);
        pair_t p;
        p.mx = SAMPLE_BITS'(a); p.my = SAMPLE_BITS'(b); p.mz = SAMPLE_BITS'(cc);
        p.rx = SAMPLE_BITS'(d); p.ry = SAMPLE_BITS'(e); p.rz = SAMPLE_BITS'(f);
        p.gap = rand_gap();
        pair_q.push_back(p);
    endtask

    task automatic add_random(input int count);
        pair_t p;
        int sc, k;
        for (int i = 0; i < count; i++)
        begin
            if (i % 60 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            sc = ($urandom_range(0, 9) < 6) ? 2 : $urandom_range(0, 1);
            p.mx = rand_sample(sc); p.my = rand_sample(sc); p.mz = rand_sample(sc);
            k = $urandom_range(0, 4);
            if (k == 0)
            begin
                // parallel or antiparallel with the measurement
                p.rx = p.mx; p.ry = p.my; p.rz = p.mz;
                if ($urandom_range(0, 1))
                begin
                    p.rx = -p.mx; p.ry = -p.my; p.rz = -p.mz;
                end
            end
            else
            begin
                sc = ($urandom_range(0, 9) < 6) ? 2 : $urandom_range(0, 1);
                p.rx = rand_sample(sc); p.ry = rand_sample(sc); p.rz = rand_sample(sc);
            end
            p.gap = rand_gap();
            pair_q.push_back(p);
        end
        no_idle = 0;
    endtask

    task automatic drain();
        wait (pair_q.size() == 0 && !start && matrix_q.size() == 0);
        repeat (LATENCY + 8) @(posedge clk);
    endtask

    task automatic write_guard(input logic [GUARD_W-1:0] g);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= g;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic [GUARD_W-1:0] guards[6];
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: extremes, zero vectors, aligned, opposed, orthogonal, tiny norms
        add_pair(0, 0, 0, 0, 0, 0);
        add_pair(0, 0, 0, 1000, -2000, 3000);
        add_pair(5000, 0, 0, 0, 0, 0);
        add_pair(32767, 32767, 32767, 32767, 32767, 32767);
        add_pair(-32768, -32768, -32768, -32768, -32768, -32768);
        add_pair(-32768, -32768, -32768, 32767, 32767, 32767);
        add_pair(32767, -32768, 0, -32768, 32767, 0);
        add_pair(1000, 0, 0, 0, 1000, 0);
        add_pair(0, 1000, 0, 0, 0, 1000);
        add_pair(0, 0, -1000, -1000, 0, 0);
        add_pair(1000, 0, 0, -1000, 0, 0);
        add_pair(1, 0, 0, 0, -1, 0);
        add_pair(1, 1, 1, -1, -1, -1);
        add_pair(-32768, 0, 0, 0, 0, 32767);
        add_pair(3, -4, 0, 1, 2, 2);
        add_pair(12000, 9000, -20000, -7000, 31000, 100);
        add_pair(32767, 1, -1, -1, 32767, 1);
        add_pair(-5, 7, -9, 11, -13, 17);
        add_random(240);
        drain();

        guards = '{16'd0, 16'hFFFF, 16'd1, 16'd300, 16'd40000, GUARD_W'($urandom)};
        for (int g = 0; g < 6; g++)
        begin
            write_guard(guards[g]);
            if (guards[g] != 1)
            begin
                add_pair(0, 0, 0, 0, 0, 0);
                add_pair(2, 0, 0, 0, 2, 0);
                add_pair(32767, 32767, 32767, -32768, -32768, -32768);
                add_pair(200, -100, 50, -200, 100, -50);
            end
            add_random(190);
            drain();
        end

        if (errors == 0)
            $display("two_vector_rotation_matrix regression: pass");
        else
            $display("two_vector_rotation_matrix regression: fail");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("two_vector_rotation_matrix regression: fail");
        $finish;
    end

endmodule
`default_nettype wire
